@@ design/tpvc_pkg.sv @@
// Shared types and constants for the triangle pair visibility cull block.
// Depends on nothing; imported by every module of the block.
package tpvc_pkg;

  localparam int W_NORM = 35;
  localparam int W_SUM  = 18;
  localparam int W_DIFF = 19;
  localparam int W_OFF  = 17;
  localparam int W_MA   = 36;
  localparam int W_MB   = 19;
  localparam int W_PROD = W_MA + W_MB;
  localparam int W_ACC  = 80;
  localparam int W_SQ   = 34;
  localparam int W_ROOT = 17;
  localparam int HI_SHIFT  = 18;
  localparam int DIV_SHIFT = 20;
  // ceil(2^20 / 3): exact floor(x / 3) for x < 2^19
  localparam logic signed [W_MA-1:0] RECIP3 = 36'sd349526;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_MUL,
    ST_DRAIN_LD,
    ST_FETCH_C,
    ST_FETCH_R,
    ST_CAP_R,
    ST_NN_MUL,
    ST_OD_MUL,
    ST_DIV_MUL,
    ST_SQ_MUL,
    ST_DRAIN_SQ,
    ST_SQRT,
    ST_FINISH
  } state_t;

  // marks products whose arrival triggers a capture
  typedef enum logic [2:0] {
    TAG_MISC,
    TAG_LD_Y0,
    TAG_LD_Z0,
    TAG_OD0,
    TAG_DIV0,
    TAG_DIV1,
    TAG_DIV2
  } tag_t;

  typedef struct packed {
    logic valid;
    logic acc_en;
    logic clr;
    logic sub;
    logic hi;
    tag_t tag;
  } mac_op_t;

  typedef struct packed {
    logic signed [W_NORM-1:0] nx;
    logic signed [W_NORM-1:0] ny;
    logic signed [W_NORM-1:0] nz;
    logic signed [W_SUM-1:0]  sx;
    logic signed [W_SUM-1:0]  sy;
    logic signed [W_SUM-1:0]  sz;
  } entry_t;

endpackage

@@ design/triangle_pair_visibility_cull_top.sv @@
// Top level of the triangle pair visibility cull: sequencer around the shared
// multiplier, the triangle store and the square root unit. Uses tpvc_pkg.
//
//   channel  dir  tdata                                          tuser
//   s_axis   in   caster, receiver, v0_x..v2_z (168 b)          cmd
//   m_axis   out  offset_x, offset_y, offset_z, mean_distance   visible
//
// A load issues 6 multiplies plus drain; a test does two store reads,
// 15 multiplies on the shared unit and 17 square root steps.
// One transaction at a time: s_axis_tready is low while a command is worked.
// Reset (rst, synchronous) clears control only; store contents are undefined.
// A stalled result holds in the output register; the next command may start.
module triangle_pair_visibility_cull_top #(
  parameter int MAX_TRIANGLES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // caster_index, receiver_index, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic [167:0] s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // offset_x, offset_y, offset_z, mean_distance, zero pad
  output logic [71:0]  m_axis_tdata,
  // visible
  output logic         m_axis_tuser
);
  import tpvc_pkg::*;

  localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

  state_t state, state_next;
  logic [2:0] cnt;

  logic                     cmd_r;
  logic [9:0]               cidx;
  logic [9:0]               ridx;
  logic signed [15:0]       vtx [9];
  logic signed [W_NORM-1:0] cn [3];
  logic signed [W_NORM-1:0] rn [3];
  logic signed [W_SUM-1:0]  cs [3];
  logic signed [W_SUM-1:0]  rs [3];
  logic signed [W_DIFF-1:0] d [3];
  logic signed [W_DIFF-1:0] dabs [3];
  logic signed [16:0]       e1 [3];
  logic signed [16:0]       e2 [3];
  logic signed [W_OFF-1:0]  off [3];
  logic signed [W_NORM-1:0] nx_r;
  logic signed [W_NORM-1:0] ny_r;
  logic                     nn_neg;
  logic                     od_pos;
  logic                     c_in;
  logic                     r_in;
  logic [1:0]               k;
  logic [W_OFF-1:0]         q;

  mac_op_t                  op;
  mac_op_t                  prod_op;
  logic signed [W_MA-1:0]   ma;
  logic signed [W_MB-1:0]   mb;
  logic signed [W_PROD-1:0] prod;
  logic signed [W_ACC-1:0]  acc;

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  logic               sqrt_start;
  logic               sqrt_done;
  logic [W_ROOT-1:0]  root;
  logic               out_load;

  assign c_in = ({22'd0, cidx} < 32'(MAX_TRIANGLES));
  assign r_in = ({22'd0, ridx} < 32'(MAX_TRIANGLES));
  assign q    = prod[DIV_SHIFT +: W_OFF];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i]   = {vtx[3+i][15], vtx[3+i]} - {vtx[i][15], vtx[i]};
      e2[i]   = {vtx[6+i][15], vtx[6+i]} - {vtx[i][15], vtx[i]};
      d[i]    = {cs[i][W_SUM-1], cs[i]} - {rs[i][W_SUM-1], rs[i]};
      dabs[i] = d[i][W_DIFF-1] ? -d[i] : d[i];
    end
  end

  tpvc_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .a       (ma),
    .b       (mb),
    .prod    (prod),
    .prod_op (prod_op),
    .acc     (acc)
  );

  tpvc_store #(.DEPTH(MAX_TRIANGLES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(cidx)),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tpvc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (acc[W_SQ-1:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser == CMD_LOAD) ? ST_LOAD_MUL : ST_FETCH_C;
        end
      end
      ST_LOAD_MUL: if (cnt == 3'd5) state_next = ST_DRAIN_LD;
      ST_DRAIN_LD: if (cnt == 3'd1) state_next = ST_IDLE;
      ST_FETCH_C:  state_next = ST_FETCH_R;
      ST_FETCH_R:  state_next = ST_CAP_R;
      ST_CAP_R:    state_next = ST_NN_MUL;
      ST_NN_MUL:   if (cnt == 3'd5) state_next = ST_OD_MUL;
      ST_OD_MUL:   if (cnt == 3'd2) state_next = ST_DIV_MUL;
      ST_DIV_MUL:  if (cnt == 3'd2) state_next = ST_SQ_MUL;
      ST_SQ_MUL:   if (cnt == 3'd2) state_next = ST_DRAIN_SQ;
      ST_DRAIN_SQ: if (cnt == 3'd1) state_next = ST_SQRT;
      ST_SQRT:     if (sqrt_done) state_next = ST_FINISH;
      ST_FINISH:   if (out_load) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    op         = '0;
    ma         = '0;
    mb         = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = AW'(cidx);
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    k          = cnt[1:0];
    mem_wdata.nx = nx_r;
    mem_wdata.ny = ny_r;
    mem_wdata.nz = acc[W_NORM-1:0];
    mem_wdata.sx = W_SUM'(vtx[0]) + W_SUM'(vtx[3]) + W_SUM'(vtx[6]);
    mem_wdata.sy = W_SUM'(vtx[1]) + W_SUM'(vtx[4]) + W_SUM'(vtx[7]);
    mem_wdata.sz = W_SUM'(vtx[2]) + W_SUM'(vtx[5]) + W_SUM'(vtx[8]);
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_LOAD_MUL: begin
        op.valid  = 1'b1;
        op.acc_en = 1'b1;
        op.clr    = ~cnt[0];
        op.sub    = cnt[0];
        unique case (cnt)
          3'd0: begin ma = W_MA'(e1[1]); mb = W_MB'(e2[2]); end
          3'd1: begin ma = W_MA'(e1[2]); mb = W_MB'(e2[1]); end
          3'd2: begin ma = W_MA'(e1[2]); mb = W_MB'(e2[0]); op.tag = TAG_LD_Y0; end
          3'd3: begin ma = W_MA'(e1[0]); mb = W_MB'(e2[2]); end
          3'd4: begin ma = W_MA'(e1[0]); mb = W_MB'(e2[1]); op.tag = TAG_LD_Z0; end
          default: begin ma = W_MA'(e1[1]); mb = W_MB'(e2[0]); end
        endcase
      end
      ST_DRAIN_LD: mem_we = (cnt == 3'd1) && c_in;
      ST_FETCH_C: mem_re = 1'b1;
      ST_FETCH_R: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(ridx);
      end
      ST_NN_MUL: begin
        k         = cnt[2:1];
        op.valid  = 1'b1;
        op.acc_en = 1'b1;
        op.clr    = (cnt == 3'd0);
        op.hi     = cnt[0];
        ma        = W_MA'(cn[k]);
        mb        = cnt[0] ? W_MB'($signed(rn[k][W_NORM-1:HI_SHIFT]))
                           : W_MB'({1'b0, rn[k][HI_SHIFT-1:0]});
      end
      ST_OD_MUL: begin
        op.valid  = 1'b1;
        op.acc_en = 1'b1;
        op.clr    = (cnt == 3'd0);
        op.tag    = (cnt == 3'd0) ? TAG_OD0 : TAG_MISC;
        ma        = W_MA'(cn[k]);
        mb        = d[k];
      end
      ST_DIV_MUL: begin
        op.valid = 1'b1;
        op.tag   = (cnt == 3'd0) ? TAG_DIV0 : ((cnt == 3'd1) ? TAG_DIV1 : TAG_DIV2);
        ma       = RECIP3;
        mb       = dabs[k];
      end
      ST_SQ_MUL: begin
        op.valid  = 1'b1;
        op.acc_en = 1'b1;
        op.clr    = (cnt == 3'd0);
        ma        = W_MA'(off[k]);
        mb        = W_MB'(off[k]);
      end
      ST_DRAIN_SQ: sqrt_start = (cnt == 3'd1);
      ST_FINISH: out_load = ~m_axis_tvalid | m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 3'd0 : cnt + 3'd1;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_r <= s_axis_tuser;
      cidx  <= s_axis_tdata[9:0];
      ridx  <= s_axis_tdata[19:10];
      for (int i = 0; i < 9; i++) begin
        vtx[i] <= s_axis_tdata[20 + 16*i +: 16];
      end
    end
    if (state == ST_FETCH_R) begin
      cn[0] <= c_in ? mem_rdata.nx : '0;
      cn[1] <= c_in ? mem_rdata.ny : '0;
      cn[2] <= c_in ? mem_rdata.nz : '0;
      cs[0] <= c_in ? mem_rdata.sx : '0;
      cs[1] <= c_in ? mem_rdata.sy : '0;
      cs[2] <= c_in ? mem_rdata.sz : '0;
    end
    if (state == ST_CAP_R) begin
      rn[0] <= r_in ? mem_rdata.nx : '0;
      rn[1] <= r_in ? mem_rdata.ny : '0;
      rn[2] <= r_in ? mem_rdata.nz : '0;
      rs[0] <= r_in ? mem_rdata.sx : '0;
      rs[1] <= r_in ? mem_rdata.sy : '0;
      rs[2] <= r_in ? mem_rdata.sz : '0;
    end
    if (prod_op.valid) begin
      unique case (prod_op.tag)
        TAG_LD_Y0: nx_r <= acc[W_NORM-1:0];
        TAG_LD_Z0: ny_r <= acc[W_NORM-1:0];
        TAG_OD0:   nn_neg <= acc[W_ACC-1];
        TAG_DIV0: begin
          od_pos <= ~acc[W_ACC-1] && (acc != '0);
          off[0] <= d[0][W_DIFF-1] ? -q : q;
        end
        TAG_DIV1:  off[1] <= d[1][W_DIFF-1] ? -q : q;
        TAG_DIV2:  off[2] <= d[2][W_DIFF-1] ? -q : q;
        default: ;
      endcase
    end
    if (out_load) begin
      m_axis_tdata <= {4'd0, root, off[2], off[1], off[0]};
      m_axis_tuser <= nn_neg && od_pos && (cidx != ridx);
    end
  end

  a_we_on_load: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (cmd_r == CMD_LOAD))
    else $error("store written during a test");

  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == ST_SQRT))
    else $error("square root finished outside its wait state");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("result raised without a finished test");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new transaction taken while one is in work");

endmodule

@@ design/tpvc_store.sv @@
// Triangle store: normal and vertex sum per slot, one write and one read port.
// Depends on tpvc_pkg for the entry layout.
module tpvc_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  tpvc_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output tpvc_pkg::entry_t rdata
);
  import tpvc_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/tpvc_mac.sv @@
// Shared 36x19 signed multiplier with registered product and 80-bit accumulator.
// Depends on tpvc_pkg for the operation descriptor.
module tpvc_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tpvc_pkg::mac_op_t                    op,
  input  logic signed [tpvc_pkg::W_MA-1:0]     a,
  input  logic signed [tpvc_pkg::W_MB-1:0]     b,
  output logic signed [tpvc_pkg::W_PROD-1:0]   prod,
  output tpvc_pkg::mac_op_t                    prod_op,
  output logic signed [tpvc_pkg::W_ACC-1:0]    acc
);
  import tpvc_pkg::*;

  logic signed [W_ACC-1:0] term;
  logic signed [W_ACC-1:0] base;

  always_comb begin
    term = W_ACC'(prod);
    if (prod_op.hi) begin
      term = term <<< HI_SHIFT;
    end
    base = prod_op.clr ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) begin
      prod_op <= '0;
    end else begin
      prod_op <= op;
    end
    if (prod_op.valid && prod_op.acc_en) begin
      acc <= prod_op.sub ? base - term : base + term;
    end
  end

endmodule

@@ design/tpvc_sqrt.sv @@
// Restoring integer square root, one result bit per cycle.
// Depends on tpvc_pkg for widths.
module tpvc_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [tpvc_pkg::W_SQ-1:0]         value,
  output logic                              done,
  output logic [tpvc_pkg::W_ROOT-1:0]       root
);
  import tpvc_pkg::*;

  logic [W_SQ-1:0] rad;
  logic [19:0]     rem;
  logic [19:0]     rem_next;
  logic [19:0]     trial;
  logic [4:0]      step;
  logic            busy;

  always_comb begin
    rem_next = {rem[17:0], rad[W_SQ-1 -: 2]};
    trial    = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 5'(W_ROOT - 1);
        rad  <= value;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= rad << 2;
        if (rem_next >= trial) begin
          rem  <= rem_next - trial;
          root <= {root[W_ROOT-2:0], 1'b1};
        end else begin
          rem  <= rem_next;
          root <= {root[W_ROOT-2:0], 1'b0};
        end
        if (step == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 5'd1;
        end
      end
    end
  end

endmodule
